FILE: rtl/core/mwd_pulse_energy_filter_unit_assert.svh
// Assertion macros for the moving-window deconvolution filter.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef MWD_PULSE_ENERGY_FILTER_UNIT_ASSERT_SVH
`define MWD_PULSE_ENERGY_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The condition must never hold at a clock edge.
`define MPEF_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("mpef: forbidden condition observed");
// When the antecedent holds, the consequent holds at the same edge.
`define MPEF_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpef: same-cycle implication violated");
// When the antecedent holds, the consequent holds at the next edge.
`define MPEF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpef: next-cycle implication violated");
`else
`define MPEF_ASSERT_NEVER(lbl, cond)
`define MPEF_ASSERT_IMPLIES(lbl, ante, cons)
`define MPEF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/mpef_pkg.sv
// Shared types, constants and width helpers for the MWD pulse energy filter.
// No dependencies; every other file of the block but the assertion header imports this package.
`default_nettype none

package mpef_pkg;

	// Fixed field and register widths.
	localparam int SAMPLE_BITS = 16;
	localparam int D_W         = SAMPLE_BITS + 1;
	localparam int M_W         = 16;
	localparam int LEN_W       = 10;
	localparam int PH_W        = 27;
	localparam int DEN_W       = M_W + LEN_W;
	localparam int DEN2_W      = DEN_W + 1;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int HIST_W      = D_W + SAMPLE_BITS;
	localparam int PROD_W      = M_W + D_W + 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_M       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_START   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LENGTH  = 2'd3;

	// Register values after reset.
	localparam logic [LEN_W-1:0] RST_WINDOW_LENGTH = 10'd500;
	localparam logic [M_W-1:0]   RST_DECAY_M       = 16'd1000;
	localparam logic [LEN_W-1:0] RST_INTEG_START   = 10'd600;
	localparam logic [LEN_W-1:0] RST_INTEG_LENGTH  = 10'd50;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic s1_step;
		logic div_num;
		logic div_abs;
		logic div_step;
		logic out_load;
	} mpef_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic s1_last;
	} mpef_stat_t;

	// Running-sum width: one difference change per sample over a whole waveform.
	function automatic int mpef_ws_width(input int idx_w);
		return D_W + 1 + idx_w;
	endfunction

	// Accumulator width: deconvolved value grown by the sample count.
	function automatic int mpef_acc_width(input int idx_w);
		int ws_w;
		int filt_w;
		ws_w   = mpef_ws_width(idx_w);
		filt_w = ((PROD_W > ws_w) ? PROD_W : ws_w) + 1;
		return filt_w + idx_w;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mpef_sample_if.sv
// Sample input channel: valid/ready handshake with one waveform sample.
// Depends on mpef_pkg for the sample width.
`default_nettype none

interface mpef_sample_if import mpef_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink (input valid, input sample, input last_sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mpef_result_if.sv
// Result output channel: valid/ready handshake with one pulse height.
// Depends on mpef_pkg for the result width.
`default_nettype none

interface mpef_result_if import mpef_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [PH_W-1:0] pulse_height;
	logic                   window_complete;

	modport source (output valid, output pulse_height, output window_complete, input ready);
	modport sink (input valid, input pulse_height, input window_complete, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mpef_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on mpef_pkg for the index and data widths.
`default_nettype none

interface mpef_cfg_if import mpef_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mpef_ctrl.sv
// Controller for the MWD pulse energy filter: sample handshake, divider sequencing
// and output register handshake. Depends on mpef_pkg.
`default_nettype none

module mpef_ctrl import mpef_pkg::*; #(
	parameter int MAX_SAMPLES = 1024
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire        out_ready,
	input  mpef_stat_t stat,
	output mpef_cmd_t  cmd
);

	localparam int IDX_W     = $clog2(MAX_SAMPLES);
	localparam int DIV_STEPS = mpef_acc_width(IDX_W) + 2;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [2:0] ST_RUN = 3'd0;
	localparam logic [2:0] ST_NUM = 3'd1;
	localparam logic [2:0] ST_ABS = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       state_next;
	logic [CNT_W-1:0] cnt_q;
	logic             s1_valid_q;
	logic             out_valid_q;
	logic             out_free;

	// Samples flow only while no division is pending and no last sample sits in stage one.
	assign in_ready  = (state_q == ST_RUN) && !(s1_valid_q && stat.s1_last);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Command decode and next state.
	always_comb begin
		cmd            = '0;
		cmd.accept     = in_valid && in_ready;
		cmd.s1_step    = s1_valid_q;
		state_next     = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (s1_valid_q && stat.s1_last) begin
					state_next = ST_NUM;
				end
			end
			ST_NUM: begin
				cmd.div_num = 1'b1;
				state_next  = ST_ABS;
			end
			ST_ABS: begin
				cmd.div_abs = 1'b1;
				state_next  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_next = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_next   = ST_RUN;
				end
			end
			default: begin
				state_next = ST_RUN;
			end
		endcase
	end

	// State, step counter and valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			cnt_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_next;
			s1_valid_q <= cmd.accept;
			if (cmd.div_abs) begin
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/mpef_datapath.sv
// Datapath for the MWD pulse energy filter: configuration registers, delay-line
// memory, difference/deconvolution stage, accumulator and radix-2 divider.
// Depends on mpef_pkg.
`default_nettype none

module mpef_datapath import mpef_pkg::*; #(
	parameter int MAX_WINDOW  = 512,
	parameter int MAX_SAMPLES = 1024
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  mpef_cmd_t                     cmd,
	output mpef_stat_t                    stat,
	input  wire                           cfg_we,
	input  wire        [CFG_IDX_W-1:0]    cfg_index,
	input  wire        [CFG_DATA_W-1:0]   cfg_data,
	input  wire signed [SAMPLE_BITS-1:0]  in_sample,
	input  wire                           in_last,
	output logic signed [PH_W-1:0]        pulse_height,
	output logic                          window_complete
);

	localparam int PTR_W  = $clog2(MAX_WINDOW);
	localparam int IDX_W  = $clog2(MAX_SAMPLES);
	localparam int WS_W   = mpef_ws_width(IDX_W);
	localparam int ACC_W  = mpef_acc_width(IDX_W);
	localparam int FILT_W = ACC_W - IDX_W;
	localparam int NUM_W  = ACC_W + 2;
	localparam int LEN_C  = ((PTR_W + 1) > LEN_W) ? (PTR_W + 1) : LEN_W;
	localparam int CMP_W  = ((IDX_W > LEN_C) ? IDX_W : LEN_C) + 2;

	localparam logic [CMP_W-1:0] MAX_WIN_C = CMP_W'(MAX_WINDOW);
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(MAX_WINDOW - 1);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_SAMPLES - 1);

	// Configuration registers.
	logic [LEN_W-1:0] wl_q;
	logic [M_W-1:0]   m_q;
	logic [LEN_W-1:0] p_q;
	logic [LEN_W-1:0] k_q;

	// Effective settings after the zero and range substitutions.
	logic [CMP_W-1:0] l_eff;
	logic [M_W-1:0]   m_eff;
	logic [LEN_W-1:0] k_eff;
	logic [CMP_W-1:0] p_ext;
	logic [CMP_W-1:0] k_ext;
	logic [DEN_W-1:0] den_q;

	// Delay-line addressing and storage.
	logic [PTR_W-1:0]  ptr_q;
	logic [PTR_W-1:0]  ptr_next;
	logic [CMP_W-1:0]  ptr_ext;
	logic [CMP_W-1:0]  rd_ext;
	logic [PTR_W-1:0]  rd_addr;
	logic [HIST_W-1:0] hist_mem [MAX_WINDOW];
	logic [HIST_W-1:0] rd_data_s1;
	logic [HIST_W-1:0] byp_data_s1;
	logic              byp_s1;
	logic [HIST_W-1:0] hist_rd;
	logic [HIST_W-1:0] wr_data;

	// Stage one payload and arithmetic.
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          last_s1;
	logic [PTR_W-1:0]              ptr_s1;
	logic signed [SAMPLE_BITS-1:0] old_raw;
	logic signed [D_W-1:0]         old_d;
	logic signed [D_W-1:0]         d_raw;
	logic signed [D_W-1:0]         d_val;
	logic signed [D_W-1:0]         od_val;
	logic [CMP_W-1:0]              i_ext;
	logic                          use_hist;
	logic                          in_win;
	logic                          complete;
	logic signed [PROD_W-1:0]      prod;
	logic signed [FILT_W-1:0]      filt;

	// Per-waveform state.
	logic [IDX_W-1:0]        idx_q;
	logic                    ovr_q;
	logic signed [WS_W-1:0]  ws_q;
	logic signed [WS_W-1:0]  ws_new;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_new;

	// Divider.
	logic signed [NUM_W-1:0] divd_q;
	logic                    neg_q;
	logic                    wc_q;
	logic [DEN2_W-1:0]       rem_q;
	logic [DEN2_W-1:0]       d2;
	logic [DEN2_W:0]         trial;
	logic [DEN2_W:0]         trial_sub;
	logic                    q_bit;

	assign stat.s1_last = last_s1;

	// Window length: zero reads as one, anything above the delay-line depth as the depth.
	always_comb begin
		l_eff = CMP_W'(wl_q);
		if (wl_q == '0) begin
			l_eff = CMP_W'(1);
		end else if (l_eff > MAX_WIN_C) begin
			l_eff = MAX_WIN_C;
		end
	end

	assign m_eff = (m_q == '0) ? M_W'(1) : m_q;
	assign k_eff = (k_q == '0) ? LEN_W'(1) : k_q;
	assign p_ext = CMP_W'(p_q);
	assign k_ext = CMP_W'(k_eff);

	// Read address trails the write pointer by the window length, modulo the depth.
	assign ptr_ext  = CMP_W'(ptr_q);
	assign rd_ext   = (ptr_ext >= l_eff) ? (ptr_ext - l_eff) : (ptr_ext + MAX_WIN_C - l_eff);
	assign rd_addr  = rd_ext[PTR_W-1:0];
	assign ptr_next = (ptr_q == PTR_LAST) ? '0 : (ptr_q + 1'b1);

	// Delay-line memory: raw sample and difference share one word.
	always_ff @(posedge clk) begin
		if (cmd.s1_step) begin
			hist_mem[ptr_s1] <= wr_data;
		end
		if (cmd.accept) begin
			rd_data_s1 <= hist_mem[rd_addr];
		end
	end

	// Stage one capture; forward the word being written when the read hits it.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_s1   <= in_sample;
			last_s1     <= in_last;
			ptr_s1      <= ptr_q;
			byp_s1      <= cmd.s1_step && (ptr_s1 == rd_addr);
			byp_data_s1 <= wr_data;
		end
	end

	assign hist_rd = byp_s1 ? byp_data_s1 : rd_data_s1;
	assign old_raw = $signed(hist_rd[SAMPLE_BITS-1:0]);
	assign old_d   = $signed(hist_rd[HIST_W-1:SAMPLE_BITS]);

	// Difference, deconvolved value and window membership.
	assign i_ext    = CMP_W'(idx_q);
	assign use_hist = (i_ext >= l_eff);
	assign d_raw    = D_W'(sample_s1) - D_W'(old_raw);
	assign d_val    = use_hist ? d_raw : '0;
	assign od_val   = use_hist ? old_d : '0;
	assign prod     = PROD_W'($signed({1'b0, m_eff})) * PROD_W'(d_val);
	assign filt     = FILT_W'(prod) + FILT_W'(ws_q);
	assign in_win   = !ovr_q && (i_ext >= p_ext) && (i_ext < (p_ext + k_ext));
	assign acc_new  = in_win ? (acc_q + ACC_W'(filt)) : acc_q;
	assign ws_new   = ws_q + WS_W'(d_val) - WS_W'(od_val);
	assign complete = ((i_ext + 1'b1) >= (p_ext + k_ext));
	assign wr_data  = {d_val, sample_s1};

	// Configuration writes and per-waveform state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q  <= RST_WINDOW_LENGTH;
			m_q   <= RST_DECAY_M;
			p_q   <= RST_INTEG_START;
			k_q   <= RST_INTEG_LENGTH;
			ptr_q <= '0;
			idx_q <= '0;
			ovr_q <= 1'b0;
			ws_q  <= '0;
			acc_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WINDOW_LENGTH: wl_q <= cfg_data[LEN_W-1:0];
					CFG_DECAY_M:       m_q  <= cfg_data[M_W-1:0];
					CFG_INTEG_START:   p_q  <= cfg_data[LEN_W-1:0];
					CFG_INTEG_LENGTH:  k_q  <= cfg_data[LEN_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				ptr_q <= ptr_next;
			end
			if (cmd.s1_step) begin
				if (last_s1) begin
					idx_q <= '0;
					ovr_q <= 1'b0;
					ws_q  <= '0;
					acc_q <= '0;
				end else begin
					if (idx_q == IDX_LAST) begin
						ovr_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
					ws_q  <= ws_new;
					acc_q <= acc_new;
				end
			end
		end
	end

	// Divisor: twice M times K.
	assign d2        = {den_q, 1'b0};
	assign trial     = {rem_q, divd_q[NUM_W-1]};
	assign q_bit     = (trial >= {1'b0, d2});
	assign trial_sub = trial - {1'b0, d2};

	// Divider: load the sum, form 2*acc + M*K, take the magnitude, then one
	// quotient bit per step shifted in behind the dividend bits.
	always_ff @(posedge clk) begin
		den_q <= DEN_W'(m_eff) * DEN_W'(k_eff);
		if (cmd.s1_step && last_s1) begin
			divd_q <= NUM_W'(acc_new);
			wc_q   <= complete;
		end else if (cmd.div_num) begin
			divd_q <= (divd_q <<< 1) + $signed(NUM_W'(den_q));
		end else if (cmd.div_abs) begin
			neg_q  <= divd_q[NUM_W-1];
			divd_q <= divd_q[NUM_W-1] ? -divd_q : divd_q;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= q_bit ? trial_sub[DEN2_W-1:0] : trial[DEN2_W-1:0];
			divd_q <= {divd_q[NUM_W-2:0], q_bit};
		end
		if (cmd.out_load) begin
			pulse_height    <= neg_q ? -divd_q[PH_W-1:0] : divd_q[PH_W-1:0];
			window_complete <= wc_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/mwd_pulse_energy_filter_unit.sv
// Moving-window deconvolution pulse energy filter, top level.
// Channels: samples (sink) takes one ADC sample and a last flag per transfer;
// results (source) gives one pulse height and a window-complete flag for each
// waveform; cfg (sink) writes register index 0..3 (window length, decay
// constant, integration start, integration length) and is always ready.
// Throughput: one sample per cycle within a waveform; the delay lines are one
// memory read at transfer and one write in the following cycle, with forwarding.
// After the transfer of a last sample the result is formed by the radix-2
// divider, which produces one quotient bit per cycle. During that time samples
// are not taken; the next waveform may start as soon as the result is in the
// output register, even while the receiver has not yet taken it.
// Receiver stall: the result waits in the output register; a further result
// waits in the divider until the register is free, and samples stop until then.
// Reset clears the control state, the running sums and the sample index, and
// restores the register defaults; the delay-line memory is not cleared.
// Configuration must be written only while no waveform is in progress.
// Depends on mpef_pkg, the channel interfaces, mpef_ctrl and mpef_datapath.
`default_nettype none

`include "mwd_pulse_energy_filter_unit_assert.svh"

module mwd_pulse_energy_filter_unit import mpef_pkg::*; #(
	parameter int MAX_WINDOW  = 512,
	parameter int MAX_SAMPLES = 1024
) (
	input wire             clk,
	input wire             arst_n,
	mpef_sample_if.sink    samples,
	mpef_result_if.source  results,
	mpef_cfg_if.sink       cfg
);

	mpef_cmd_t  cmd;
	mpef_stat_t stat;
	logic       in_ready;
	logic       out_valid;
	logic       cfg_we;
	logic       div_busy;

	// Configuration writes complete in the cycle they are offered.
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	assign samples.ready = in_ready;
	assign results.valid = out_valid;

	// Any divider or output-load command.
	assign div_busy = cmd.div_num || cmd.div_abs || cmd.div_step || cmd.out_load;

	mpef_ctrl #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mpef_datapath #(
		.MAX_WINDOW  (MAX_WINDOW),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.in_sample       (samples.sample),
		.in_last         (samples.last_sample),
		.pulse_height    (results.pulse_height),
		.window_complete (results.window_complete)
	);

	// The sample stage and the divider never work in the same cycle.
	`MPEF_ASSERT_NEVER(a_stage_exclusive, cmd.s1_step && div_busy)
	// A new result is loaded only when the output register is free or being taken.
	`MPEF_ASSERT_IMPLIES(a_no_overwrite, cmd.out_load, !results.valid || results.ready)
	// Once a last sample is processed, samples stall while the division runs.
	`MPEF_ASSERT_NEXT(a_stall_after_last, cmd.s1_step && stat.s1_last, !samples.ready)

endmodule

`default_nettype wire
